// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL file that carries checks.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SQVT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqvt assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SQVT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqvt assertion failed");

`endif

// ----- hw/rtl/sqvt_pkg.sv -----
// Shared types, constants and tables of the sprite quad vertex transform.
// No dependencies.
package sqvt_pkg;

    localparam int TRIG_FRAC_BITS_DEF  = 14;
    localparam int MAX_TEXTURE_DIM_DEF = 4096;
    localparam int CORDIC_STEPS        = 20;
    localparam int DIV_STEPS           = 27;   // 13-bit edge << 14
    localparam int CNT_W               = 5;
    localparam int POS_MAX             = 524287;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEX_W  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_H  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM = 2'd2;

    // corners
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd3;

    // color types
    localparam logic [2:0] COLOR_WHITE  = 3'd0;
    localparam logic [2:0] COLOR_RED    = 3'd1;
    localparam logic [2:0] COLOR_YELLOW = 3'd2;
    localparam logic [2:0] COLOR_GREEN  = 3'd3;
    localparam logic [2:0] COLOR_GREY   = 3'd4;

    localparam logic [31:0] RESET_COLOR = 32'hFFFF_FFFF;
    localparam logic [12:0] RESET_TEX   = 13'd256;

    typedef struct packed {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic [11:0]        src_x;
        logic [11:0]        src_y;
        logic [11:0]        src_w;
        logic [11:0]        src_h;
        logic signed [15:0] pivot_x;
        logic signed [15:0] pivot_y;
        logic [15:0]        scale_x;
        logic [15:0]        scale_y;
        logic [15:0]        angle;
        logic [2:0]         color_type;
    } t_in_item;

    typedef struct packed {
        logic signed [19:0] vert_x;
        logic signed [19:0] vert_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [31:0]        vert_color;
        logic [1:0]         corner;
        logic               last_corner;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic             iter;
        logic             cordic;
        logic [CNT_W-1:0] step;
        logic             trig_fin;
        logic             mul_a;
        logic             mul_b;
        logic             out_load;
        logic [1:0]       corner;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic signed [31:0] atan_turn(input logic [CNT_W-1:0] idx);
        logic signed [31:0] r;
        case (idx)
            5'd0:    r = 32'sd536870912;
            5'd1:    r = 32'sd316933406;
            5'd2:    r = 32'sd167458907;
            5'd3:    r = 32'sd85004756;
            5'd4:    r = 32'sd42667331;
            5'd5:    r = 32'sd21354465;
            5'd6:    r = 32'sd10679838;
            5'd7:    r = 32'sd5340245;
            5'd8:    r = 32'sd2670163;
            5'd9:    r = 32'sd1335087;
            5'd10:   r = 32'sd667544;
            5'd11:   r = 32'sd333772;
            5'd12:   r = 32'sd166886;
            5'd13:   r = 32'sd83443;
            5'd14:   r = 32'sd41722;
            5'd15:   r = 32'sd20861;
            5'd16:   r = 32'sd10430;
            5'd17:   r = 32'sd5215;
            5'd18:   r = 32'sd2608;
            5'd19:   r = 32'sd1304;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] preset_color(input logic [2:0] ct);
        logic [31:0] r;
        case (ct)
            COLOR_WHITE:  r = 32'hFFFF_FFFF;
            COLOR_RED:    r = 32'hFFFF_0000;
            COLOR_YELLOW: r = 32'hFFFF_FF00;
            COLOR_GREEN:  r = 32'hFF00_FF00;
            COLOR_GREY:   r = 32'hFF78_7878;
            default:      r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/sqvt_div.sv -----
// Restoring divider, one quotient bit per cycle while i_step is high, result saturated to 16 bits.
// Depends on sqvt_pkg.
module sqvt_div
    import sqvt_pkg::*;
#(
    parameter int DW = 13
) (
    input  logic                 i_clk,
    input  logic                 i_start,
    input  logic                 i_step,
    input  logic [DIV_STEPS-1:0] i_num,
    input  logic [DW-1:0]        i_den,
    output logic [15:0]          o_quo
);

    logic [DIV_STEPS-1:0] r_num, n_num;
    logic [DIV_STEPS-1:0] r_quo, n_quo;
    logic [DW-1:0]        r_rem, n_rem;
    logic [DW-1:0]        r_den;
    logic [DW:0]          rem_sh;
    logic [DW:0]          rem_sub;
    logic                 ge;

    always_comb begin
        rem_sh  = {r_rem, r_num[DIV_STEPS-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
        n_rem   = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        n_num   = {r_num[DIV_STEPS-2:0], 1'b0};
        n_quo   = {r_quo[DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_quo <= '0;
            r_den <= i_den;
        end else if (i_step) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo = (|r_quo[DIV_STEPS-1:16]) ? 16'hFFFF : r_quo[15:0];

endmodule

// ----- hw/rtl/sqvt_dp.sv -----
// Datapath: CORDIC sine/cosine, UV dividers, corner transform and output register.
// Depends on sqvt_pkg and sqvt_div.
module sqvt_dp
    import sqvt_pkg::*;
#(
    parameter int TRIG_FRAC_BITS  = TRIG_FRAC_BITS_DEF,
    parameter int MAX_TEXTURE_DIM = MAX_TEXTURE_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  t_in_item              i_in_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    localparam int TW  = TRIG_FRAC_BITS + 2;
    localparam int DW  = $clog2(MAX_TEXTURE_DIM + 1);
    localparam int SH  = 12 + TRIG_FRAC_BITS;
    localparam int PRW = 35 + TW;
    localparam int PW  = TRIG_FRAC_BITS + 40;
    localparam int RSH = 30 - TRIG_FRAC_BITS;

    localparam logic signed [31:0]   TRIG_HALF = 32'sd1 <<< (RSH - 1);
    localparam logic signed [PW-1:0] POS_HALF  = PW'(1) <<< (SH - 1);
    localparam logic signed [PW-1:0] POS_HI    = PW'(POS_MAX);
    localparam logic signed [PW-1:0] POS_LO    = -PW'(POS_MAX) - PW'(1);
    localparam logic [31:0]          MAX_DIM   = 32'(MAX_TEXTURE_DIM);

    // configuration and held color
    logic [12:0] r_tex_w, r_tex_h;
    logic [31:0] r_held;

    // item and trig state
    t_in_item            r_item;
    logic signed [31:0]  r_x, r_y, r_z;
    logic signed [31:0]  n_x, n_y, n_z;
    logic signed [31:0]  x_sh, y_sh, atan_v;
    logic signed [31:0]  x_rnd, y_rnd;
    logic signed [TW-1:0] xr, yr;
    logic [1:0]          r_quad;
    logic signed [TW-1:0] r_co, r_si, n_co, n_si;

    // corner products
    logic signed [17:0]  ox, oy;
    logic signed [16:0]  scx, scy;
    logic signed [34:0]  r_ax, r_ay, n_ax, n_ay;
    logic signed [PRW-1:0] r_pxa, r_pxb, r_pya, r_pyb;
    logic signed [16:0]  dx_m, dy_m;
    logic signed [PW-1:0] sum_x, sum_y, rs_x, rs_y;
    logic signed [19:0]  sat_x, sat_y;

    // dividers
    logic [DW-1:0]        den_w, den_h;
    logic [12:0]          e_u0, e_u1, e_v0, e_v1;
    logic [DIV_STEPS-1:0] num_u0, num_u1, num_v0, num_v1;
    logic [15:0]          q_u0, q_u1, q_v0, q_v1;

    t_out_item r_out;
    logic      r_out_valid;

    // divisor clamped to [1, MAX_TEXTURE_DIM]
    function automatic logic [DW-1:0] clamp_dim(input logic [12:0] d);
        logic [DW-1:0] r;
        if (d == 13'd0) begin
            r = DW'(1);
        end else if (32'(d) > MAX_DIM) begin
            r = DW'(MAX_TEXTURE_DIM);
        end else begin
            r = DW'(d);
        end
        return r;
    endfunction

    always_comb begin
        den_w  = clamp_dim(r_tex_w);
        den_h  = clamp_dim(r_tex_h);
        e_u0   = {1'b0, i_in_item.src_x};
        e_u1   = 13'(i_in_item.src_x) + 13'(i_in_item.src_w);
        e_v0   = {1'b0, i_in_item.src_y};
        e_v1   = 13'(i_in_item.src_y) + 13'(i_in_item.src_h);
        num_u0 = {e_u0, 14'b0} + DIV_STEPS'(den_w >> 1);
        num_u1 = {e_u1, 14'b0} + DIV_STEPS'(den_w >> 1);
        num_v0 = {e_v0, 14'b0} + DIV_STEPS'(den_h >> 1);
        num_v1 = {e_v1, 14'b0} + DIV_STEPS'(den_h >> 1);
    end

    sqvt_div #(.DW(DW)) u_div_u0 (
        .i_clk(i_clk), .i_start(i_cmd.start), .i_step(i_cmd.iter),
        .i_num(num_u0), .i_den(den_w), .o_quo(q_u0)
    );
    sqvt_div #(.DW(DW)) u_div_u1 (
        .i_clk(i_clk), .i_start(i_cmd.start), .i_step(i_cmd.iter),
        .i_num(num_u1), .i_den(den_w), .o_quo(q_u1)
    );
    sqvt_div #(.DW(DW)) u_div_v0 (
        .i_clk(i_clk), .i_start(i_cmd.start), .i_step(i_cmd.iter),
        .i_num(num_v0), .i_den(den_h), .o_quo(q_v0)
    );
    sqvt_div #(.DW(DW)) u_div_v1 (
        .i_clk(i_clk), .i_start(i_cmd.start), .i_step(i_cmd.iter),
        .i_num(num_v1), .i_den(den_h), .o_quo(q_v1)
    );

    // CORDIC rotation step
    always_comb begin
        x_sh   = r_x >>> i_cmd.step;
        y_sh   = r_y >>> i_cmd.step;
        atan_v = atan_turn(i_cmd.step);
        if (!r_z[31]) begin
            n_x = r_x - y_sh;
            n_y = r_y + x_sh;
            n_z = r_z - atan_v;
        end else begin
            n_x = r_x + y_sh;
            n_y = r_y - x_sh;
            n_z = r_z + atan_v;
        end
    end

    // round to trig precision and fold in the quadrant
    always_comb begin
        x_rnd = (r_x + TRIG_HALF) >>> RSH;
        y_rnd = (r_y + TRIG_HALF) >>> RSH;
        xr    = x_rnd[TW-1:0];
        yr    = y_rnd[TW-1:0];
        unique case (r_quad)
            2'd0: begin n_co = xr;  n_si = yr;  end
            2'd1: begin n_co = -yr; n_si = xr;  end
            2'd2: begin n_co = -xr; n_si = -yr; end
            2'd3: begin n_co = yr;  n_si = -xr; end
            default: begin n_co = xr; n_si = yr; end
        endcase
    end

    // corner offset from pivot, times scale
    always_comb begin
        ox   = (i_cmd.corner[0] ? $signed({2'b0, r_item.src_w, 4'b0}) : 18'sd0)
               - 18'(r_item.pivot_x);
        oy   = (i_cmd.corner[1] ? $signed({2'b0, r_item.src_h, 4'b0}) : 18'sd0)
               - 18'(r_item.pivot_y);
        scx  = $signed({1'b0, r_item.scale_x});
        scy  = $signed({1'b0, r_item.scale_y});
        n_ax = ox * scx;
        n_ay = oy * scy;
    end

    // rotated sum plus destination minus half a pixel, rounded and saturated
    always_comb begin
        dx_m  = 17'(r_item.dest_x) - 17'sd8;
        dy_m  = 17'(r_item.dest_y) - 17'sd8;
        sum_x = PW'(r_pxa) - PW'(r_pxb) + (PW'(dx_m) <<< SH) + POS_HALF;
        sum_y = PW'(r_pya) + PW'(r_pyb) + (PW'(dy_m) <<< SH) + POS_HALF;
        rs_x  = sum_x >>> SH;
        rs_y  = sum_y >>> SH;
        if (rs_x > POS_HI) begin
            sat_x = 20'sh7FFFF;
        end else if (rs_x < POS_LO) begin
            sat_x = 20'sh80000;
        end else begin
            sat_x = rs_x[19:0];
        end
        if (rs_y > POS_HI) begin
            sat_y = 20'sh7FFFF;
        end else if (rs_y < POS_LO) begin
            sat_y = 20'sh80000;
        end else begin
            sat_y = rs_y[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= RESET_TEX;
            r_tex_h <= RESET_TEX;
            r_held  <= RESET_COLOR;
        end else begin
            if (i_cmd.start && i_in_item.color_type <= COLOR_GREY) begin
                r_held <= preset_color(i_in_item.color_type);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TEX_W:  r_tex_w <= i_cfg_wdata[12:0];
                    REG_TEX_H:  r_tex_h <= i_cfg_wdata[12:0];
                    REG_CUSTOM: r_held  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_item <= i_in_item;
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= $signed({2'b0, i_in_item.angle[13:0], 16'b0});
            r_quad <= i_in_item.angle[15:14];
        end else if (i_cmd.cordic) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
        if (i_cmd.trig_fin) begin
            r_co <= n_co;
            r_si <= n_si;
        end
        if (i_cmd.mul_a) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
        end
        if (i_cmd.mul_b) begin
            r_pxa <= r_ax * r_co;
            r_pxb <= r_ay * r_si;
            r_pya <= r_ax * r_si;
            r_pyb <= r_ay * r_co;
        end
        if (i_cmd.out_load) begin
            r_out.vert_x      <= sat_x;
            r_out.vert_y      <= sat_y;
            r_out.tex_u       <= i_cmd.corner[0] ? q_u1 : q_u0;
            r_out.tex_v       <= i_cmd.corner[1] ? q_v1 : q_v0;
            r_out.vert_color  <= r_held;
            r_out.corner      <= i_cmd.corner;
            r_out.last_corner <= i_cmd.corner == CORNER_BR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;

endmodule

// ----- hw/rtl/sqvt_ctrl.sv -----
// Controller: sequences trig/divide iterations and the four corner passes.
// Depends on sqvt_pkg.
module sqvt_ctrl
    import sqvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ITER = 6'b000010,
        S_FIN  = 6'b000100,
        S_MULA = 6'b001000,
        S_MULB = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_corner, n_corner;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_corner = r_corner;
        o_cmd    = '0;
        o_cmd.step   = r_cnt;
        o_cmd.corner = r_corner;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_ITER;
                end
            end
            S_ITER: begin
                o_cmd.iter   = 1'b1;
                o_cmd.cordic = r_cnt < CNT_W'(CORDIC_STEPS);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.trig_fin = 1'b1;
                n_corner       = CORNER_TL;
                n_state        = S_MULA;
            end
            S_MULA: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MULB;
            end
            S_MULB: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_corner == CORNER_BR) begin
                        n_state = S_IDLE;
                    end else begin
                        n_corner = r_corner + 1'b1;
                        n_state  = S_MULA;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_corner <= CORNER_TL;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_corner <= n_corner;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

// ----- hw/rtl/sprite_quad_vertex_transform_unit.sv -----
// Sprite quad vertex transform: one item in, four vertices out (TL, TR, BL, BR).
// The 27-step UV dividers run with the 20-step CORDIC beside them; after the FIN state
// each corner pass runs the MULA, MULB and OUT states, and a stalled output holds OUT.
// A new item is accepted only when idle, after the last vertex of the quad is loaded.
// Reset (synchronous, active low): idle, no output, textures 256x256, color white.
module sprite_quad_vertex_transform_unit
    import sqvt_pkg::*;
#(
    parameter int TRIG_FRAC_BITS  = TRIG_FRAC_BITS_DEF,
    parameter int MAX_TEXTURE_DIM = MAX_TEXTURE_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

`include "assert_macros.svh"

    t_dp_cmd cmd;
    t_dp_sts sts;

    sqvt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    sqvt_dp #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .MAX_TEXTURE_DIM(MAX_TEXTURE_DIM)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    // an accepted item keeps the input side busy
    `SQVT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a vertex other than the last one means the quad is still in flight
    `SQVT_ASSERT_IMP(a_quad_in_flight, i_clk, i_rst_n, o_out_valid && !o_out_item.last_corner, o_in_stall)
    // no new item while a load is being issued
    `SQVT_ASSERT_IMP(a_load_not_idle, i_clk, i_rst_n, cmd.out_load, o_in_stall)

endmodule
